// File: hw/rtl/magnetometer_heading_hard_iron_defines.svh
// assertion helpers used by the top-level rtl
`ifndef MAGNETOMETER_HEADING_HARD_IRON_DEFINES_SVH
`define MAGNETOMETER_HEADING_HARD_IRON_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define MHH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define MHH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mhh_pkg.sv
package mhh_pkg;

   localparam int SAMPLE_BITS       = 18;
   localparam int CORDIC_STEPS      = 16;  // at most TAB_LEN
   localparam int HEADING_FRAC_BITS = 6;

   localparam int ANG_BITS      = 24;
   localparam int TAB_LEN       = 24;
   localparam int TAB_IDX_W     = 5;
   localparam int PRESCALE_BITS = 8;

   localparam int FIELD_W    = SAMPLE_BITS + 1;
   localparam int SUM_W      = SAMPLE_BITS + 2;
   localparam int HEADING_W  = 9 + HEADING_FRAC_BITS;
   localparam int CORDIC_W   = FIELD_W + PRESCALE_BITS + 3;
   localparam int Z_W        = 35;
   localparam int STEP_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int HEAD_SHIFT = ANG_BITS - HEADING_FRAC_BITS;

   localparam logic signed [Z_W-1:0] DEG180   = Z_W'(180) <<< ANG_BITS;
   localparam logic signed [Z_W-1:0] HALF_LSB = Z_W'(1) <<< (HEAD_SHIFT - 1);

   localparam logic [HEADING_W-1:0] HEADING_MID = HEADING_W'(180) << HEADING_FRAC_BITS;
   localparam logic [HEADING_W-1:0] HEADING_MAX = HEADING_W'(360) << HEADING_FRAC_BITS;

   localparam logic signed [FIELD_W-1:0] FIELD_LIMIT = FIELD_W'((1 << SAMPLE_BITS) - 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TRACK_ENABLE = CSR_ADDR_W'(0);

   typedef struct packed {
      logic              load;
      logic              rotate;
      logic [STEP_W-1:0] step;
   } cordic_ctl_type;

   // atan(2^-i) in 2^-24 degree
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      case (idx)
         5'd0:    return Z_W'(754974720);
         5'd1:    return Z_W'(445687602);
         5'd2:    return Z_W'(235489088);
         5'd3:    return Z_W'(119537938);
         5'd4:    return Z_W'(60000934);
         5'd5:    return Z_W'(30029717);
         5'd6:    return Z_W'(15018523);
         5'd7:    return Z_W'(7509720);
         5'd8:    return Z_W'(3754917);
         5'd9:    return Z_W'(1877466);
         5'd10:   return Z_W'(938734);
         5'd11:   return Z_W'(469367);
         5'd12:   return Z_W'(234684);
         5'd13:   return Z_W'(117342);
         5'd14:   return Z_W'(58671);
         5'd15:   return Z_W'(29335);
         5'd16:   return Z_W'(14668);
         5'd17:   return Z_W'(7334);
         5'd18:   return Z_W'(3667);
         5'd19:   return Z_W'(1833);
         5'd20:   return Z_W'(917);
         5'd21:   return Z_W'(458);
         5'd22:   return Z_W'(229);
         5'd23:   return Z_W'(115);
         default: return Z_W'(0);
      endcase
   endfunction

endpackage

// File: hw/rtl/mhh_cordic.sv
module mhh_cordic (
   input  logic                                  clock,
   input  mhh_pkg::cordic_ctl_type               ctl,
   input  logic signed [mhh_pkg::FIELD_W-1:0]    field_x,
   input  logic signed [mhh_pkg::FIELD_W-1:0]    field_y,
   output logic [mhh_pkg::HEADING_W-1:0]         heading
);

   logic signed [mhh_pkg::CORDIC_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [mhh_pkg::Z_W-1:0]      z_ff, z_in;
   logic                                zero_ff, zero_in;

   logic signed [mhh_pkg::CORDIC_W-1:0] sx, sy, da, db;
   logic signed [mhh_pkg::Z_W-1:0]      ang, hsum;

   assign sx  = mhh_pkg::CORDIC_W'(field_x) <<< mhh_pkg::PRESCALE_BITS;
   assign sy  = mhh_pkg::CORDIC_W'(field_y) <<< mhh_pkg::PRESCALE_BITS;
   assign da  = b_ff >>> ctl.step;
   assign db  = a_ff >>> ctl.step;
   assign ang = mhh_pkg::atan_entry(mhh_pkg::TAB_IDX_W'(ctl.step));

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      if (ctl.load) begin
         zero_in = (field_x == '0) && (field_y == '0);
         // pre-rotate by 180 degrees when the second coordinate (field_y) is positive
         if (field_y > 0) begin
            a_in = sy;
            b_in = -sx;
            z_in = (field_x >= 0) ? mhh_pkg::DEG180 : -mhh_pkg::DEG180;
         end else begin
            a_in = -sy;
            b_in = sx;
            z_in = '0;
         end
      end else if (ctl.rotate) begin
         if (b_ff > 0) begin
            a_in = a_ff + da;
            b_in = b_ff - db;
            z_in = z_ff + ang;
         end else begin
            a_in = a_ff - da;
            b_in = b_ff + db;
            z_in = z_ff - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   // shift to 0..360, clamp, round to nearest
   assign hsum = z_ff + (mhh_pkg::DEG180 + mhh_pkg::HALF_LSB);

   always_comb begin
      if (zero_ff) begin
         heading = mhh_pkg::HEADING_MID;
      end else if (z_ff < -mhh_pkg::DEG180) begin
         heading = '0;
      end else if (z_ff > mhh_pkg::DEG180) begin
         heading = mhh_pkg::HEADING_MAX;
      end else begin
         heading = hsum[mhh_pkg::HEAD_SHIFT +: mhh_pkg::HEADING_W];
      end
   end

endmodule

// File: hw/rtl/magnetometer_heading_hard_iron.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_ready   set_x/y/z, reset_x/y/z, restart_track
// rsp       out        rsp_valid/rsp_ready   field_x/y/z, heading, offset_x/y_sum
// csr       in/out     apb, pready tied high track_enable at byte address 0
//
// an item passes through accept, setup, one cordic rotation per cycle in the shared
// add/shift unit, and finish.
// req_ready is high only while idle; a finished item waits in the output register,
// and the next item may be accepted while it waits, but its finish stalls until
// the previous result is taken. synchronous active-high reset clears the control,
// track_enable and the min/max trackers.

`include "magnetometer_heading_hard_iron_defines.svh"

module magnetometer_heading_hard_iron (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mhh_pkg::SAMPLE_BITS-1:0]        req_set_x,
   input  logic [mhh_pkg::SAMPLE_BITS-1:0]        req_set_y,
   input  logic [mhh_pkg::SAMPLE_BITS-1:0]        req_set_z,
   input  logic [mhh_pkg::SAMPLE_BITS-1:0]        req_reset_x,
   input  logic [mhh_pkg::SAMPLE_BITS-1:0]        req_reset_y,
   input  logic [mhh_pkg::SAMPLE_BITS-1:0]        req_reset_z,
   input  logic                                   req_restart_track,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mhh_pkg::FIELD_W-1:0]     rsp_field_x,
   output logic signed [mhh_pkg::FIELD_W-1:0]     rsp_field_y,
   output logic signed [mhh_pkg::FIELD_W-1:0]     rsp_field_z,
   output logic [mhh_pkg::HEADING_W-1:0]          rsp_heading,
   output logic signed [mhh_pkg::SUM_W-1:0]       rsp_offset_x_sum,
   output logic signed [mhh_pkg::SUM_W-1:0]       rsp_offset_y_sum,

   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mhh_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [mhh_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [mhh_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_ROT   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [mhh_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       track_enable_ff, track_enable_in;

   // latched item
   logic signed [mhh_pkg::FIELD_W-1:0] fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic                               restart_ff, restart_in;

   // hard-iron trackers
   logic signed [mhh_pkg::FIELD_W-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [mhh_pkg::FIELD_W-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic signed [mhh_pkg::FIELD_W-1:0] min_x_base, max_x_base, min_y_base, max_y_base;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [mhh_pkg::FIELD_W-1:0] rsp_fx_ff, rsp_fy_ff, rsp_fz_ff;
   logic [mhh_pkg::HEADING_W-1:0]      rsp_head_ff;
   logic signed [mhh_pkg::SUM_W-1:0]   rsp_sx_ff, rsp_sy_ff;
   logic                               rsp_load;

   mhh_pkg::cordic_ctl_type        cordic_ctl;
   logic [mhh_pkg::HEADING_W-1:0]  cordic_heading;
   logic                           req_take, csr_write;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == mhh_pkg::ADDR_TRACK_ENABLE) ?
                       mhh_pkg::CSR_DATA_W'(track_enable_ff) : '0;

   always_comb begin
      track_enable_in = track_enable_ff;
      if (csr_write && (csr_paddr == mhh_pkg::ADDR_TRACK_ENABLE)) begin
         track_enable_in = csr_pwdata[0];
      end
   end

   // offset-cancelled fields, formed at accept
   always_comb begin
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      fz_in      = fz_ff;
      restart_in = restart_ff;
      if (req_take) begin
         fx_in      = $signed({1'b0, req_set_x}) - $signed({1'b0, req_reset_x});
         fy_in      = $signed({1'b0, req_set_y}) - $signed({1'b0, req_reset_y});
         fz_in      = $signed({1'b0, req_set_z}) - $signed({1'b0, req_reset_z});
         restart_in = req_restart_track;
      end
   end

   // restart clears first, then the sample is tracked only when enabled
   assign min_x_base = restart_ff ? mhh_pkg::FIELD_LIMIT : min_x_ff;
   assign max_x_base = restart_ff ? -mhh_pkg::FIELD_LIMIT : max_x_ff;
   assign min_y_base = restart_ff ? mhh_pkg::FIELD_LIMIT : min_y_ff;
   assign max_y_base = restart_ff ? -mhh_pkg::FIELD_LIMIT : max_y_ff;

   always_comb begin
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      if (state_ff == ST_SETUP) begin
         min_x_in = (track_enable_ff && (fx_ff < min_x_base)) ? fx_ff : min_x_base;
         max_x_in = (track_enable_ff && (fx_ff > max_x_base)) ? fx_ff : max_x_base;
         min_y_in = (track_enable_ff && (fy_ff < min_y_base)) ? fy_ff : min_y_base;
         max_y_in = (track_enable_ff && (fy_ff > max_y_base)) ? fy_ff : max_y_base;
      end
   end

   // sequencer
   always_comb begin
      state_in          = state_ff;
      step_in           = step_ff;
      cordic_ctl.load   = 1'b0;
      cordic_ctl.rotate = 1'b0;
      cordic_ctl.step   = step_ff;
      rsp_load          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // pre-rotation and zero check into the cordic registers
            cordic_ctl.load = 1'b1;
            step_in         = '0;
            state_in        = ST_ROT;
         end
         ST_ROT: begin
            cordic_ctl.rotate = 1'b1;
            if (step_ff == mhh_pkg::STEP_W'(mhh_pkg::CORDIC_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   mhh_cordic u_cordic (
      .clock   (clock),
      .ctl     (cordic_ctl),
      .field_x (fx_ff),
      .field_y (fy_ff),
      .heading (cordic_heading)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         track_enable_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         min_x_ff        <= mhh_pkg::FIELD_LIMIT;
         max_x_ff        <= -mhh_pkg::FIELD_LIMIT;
         min_y_ff        <= mhh_pkg::FIELD_LIMIT;
         max_y_ff        <= -mhh_pkg::FIELD_LIMIT;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         track_enable_ff <= track_enable_in;
         rsp_valid_ff    <= rsp_valid_in;
         min_x_ff        <= min_x_in;
         max_x_ff        <= max_x_in;
         min_y_ff        <= min_y_in;
         max_y_ff        <= max_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      fz_ff      <= fz_in;
      restart_ff <= restart_in;
      if (rsp_load) begin
         rsp_fx_ff   <= fx_ff;
         rsp_fy_ff   <= fy_ff;
         rsp_fz_ff   <= fz_ff;
         rsp_head_ff <= cordic_heading;
         rsp_sx_ff   <= mhh_pkg::SUM_W'(max_x_ff) + mhh_pkg::SUM_W'(min_x_ff);
         rsp_sy_ff   <= mhh_pkg::SUM_W'(max_y_ff) + mhh_pkg::SUM_W'(min_y_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_x      = rsp_fx_ff;
   assign rsp_field_y      = rsp_fy_ff;
   assign rsp_field_z      = rsp_fz_ff;
   assign rsp_heading      = rsp_head_ff;
   assign rsp_offset_x_sum = rsp_sx_ff;
   assign rsp_offset_y_sum = rsp_sy_ff;

   // checks

   // an accepted item always goes to setup next
   `MHH_ASSERT_NEXT(a_accept_setup, clock, reset, req_take, state_ff == ST_SETUP, "accept did not start setup")

   // a finished item never overwrites a result that is still waiting
   `MHH_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE, "result overwritten while stalled")

   // heading stays within the full circle
   `MHH_ASSERT_NOW(a_heading_range, clock, reset, rsp_valid_ff, rsp_head_ff <= mhh_pkg::HEADING_MAX, "heading out of range")

   // the x tracker is either ordered or still cleared
   `MHH_ASSERT_NOW(a_track_order, clock, reset, 1'b1, (min_x_ff <= max_x_ff) || ((min_x_ff == mhh_pkg::FIELD_LIMIT) && (max_x_ff == -mhh_pkg::FIELD_LIMIT)), "x min above max")

endmodule
